// ----- hdl/pob_pkg.sv -----
// shared constants, types and the sine table for the oscillator bank
`default_nettype none
package pob_pkg;

  localparam int VOICES     = 16;
  localparam int SINE_DEPTH = 1024;
  localparam int PHASE_BITS = 32;

  localparam int VIDX_W   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SIDX_W   = $clog2(SINE_DEPTH);
  localparam int FREQ_W   = 24;
  localparam int GAIN_W   = 16;
  localparam int SR_W     = 18;
  localparam int SAMPLE_W = 20;
  localparam int LUT_W    = 16;
  localparam int PROD_W   = GAIN_W + LUT_W;
  localparam int DVD_W    = FREQ_W + PHASE_BITS - 8;
  localparam int DIV_STEPS = DVD_W;
  localparam int DCNT_W   = $clog2(DIV_STEPS);
  localparam logic [SR_W-1:0] SR_RESET = SR_W'(48000);

  localparam longint unsigned Q30_ONE    = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_NOTE_ON = 2'd1,
    OP_NOTE_OFF = 2'd2,
    OP_ALL_OFF = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    TB_SILENT0 = 2'd0,
    TB_SQUARE  = 2'd1,
    TB_SINE    = 2'd2,
    TB_SILENT3 = 2'd3
  } timbre_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK_RUN,
    ST_TICK_DRAIN,
    ST_TICK_OUT,
    ST_OFF_SCAN,
    ST_DIV_RUN
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic tick_start;
    logic tick_rd;
    logic on_start;
    logic div_step;
    logic off_start;
    logic off_step;
    logic all_off;
    logic out_load;
  } pob_cmd_t;

  // status back to the controller
  typedef struct packed {
    logic vidx_last;
    logic div_last;
    logic match;
    logic pipe_busy;
    logic out_free;
  } pob_stat_t;

  typedef logic signed [LUT_W-1:0] sine_lut_t [SINE_DEPTH];

  // sin(pi/2 * r/depth) in unsigned q30, truncating at every step
  function automatic longint unsigned quarter_sine(input longint unsigned r);
    longint unsigned u, x, x2, t;
    u  = (r << 30) / SINE_DEPTH;
    x  = (u * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    return (x * t) >> 30;
  endfunction

  // full cycle table with quarter-wave folding
  function automatic sine_lut_t build_sine();
    sine_lut_t lut;
    longint unsigned k4, q, r, v, m;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      k4 = 64'(4 * k);
      q  = k4 / SINE_DEPTH;
      r  = k4 % SINE_DEPTH;
      v  = quarter_sine(q[0] ? (64'(SINE_DEPTH) - r) : r);
      m  = (v * 64'd32767 + (64'd1 << 29)) >> 30;
      lut[k] = (q >= 2) ? -LUT_W'(m) : LUT_W'(m);
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine();

endpackage
`default_nettype wire

// ----- hdl/pob_ctrl.sv -----
// controller state machine for the oscillator bank
`default_nettype none
module pob_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [1:0]        in_op,
  output logic                   in_ready,
  input  wire pob_pkg::pob_stat_t stat,
  output pob_pkg::pob_cmd_t      cmd
);
  import pob_pkg::*;

  state_t state_r, state_nxt;
  logic   acc;

  assign acc = in_valid && in_ready;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (op_t'(in_op))
            OP_TICK:     state_nxt = ST_TICK_RUN;
            OP_NOTE_ON:  state_nxt = ST_DIV_RUN;
            OP_NOTE_OFF: state_nxt = ST_OFF_SCAN;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_TICK_RUN:   if (stat.vidx_last) state_nxt = ST_TICK_DRAIN;
      ST_TICK_DRAIN: if (!stat.pipe_busy) state_nxt = ST_TICK_OUT;
      ST_TICK_OUT:   if (stat.out_free) state_nxt = ST_IDLE;
      ST_OFF_SCAN:   if (stat.match || stat.vidx_last) state_nxt = ST_IDLE;
      ST_DIV_RUN:    if (stat.div_last) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (acc) begin
          case (op_t'(in_op))
            OP_TICK:     cmd.tick_start = 1'b1;
            OP_NOTE_ON:  cmd.on_start   = 1'b1;
            OP_NOTE_OFF: cmd.off_start  = 1'b1;
            default:     cmd.all_off    = 1'b1;
          endcase
        end
      end
      ST_TICK_RUN: cmd.tick_rd  = 1'b1;
      ST_TICK_OUT: cmd.out_load = stat.out_free;
      ST_OFF_SCAN: cmd.off_step = 1'b1;
      ST_DIV_RUN:  cmd.div_step = 1'b1;
      default:     cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/pob_datapath.sv -----
// voice store, phase step divider, mixing pipeline and output register
`default_nettype none
module pob_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [pob_pkg::SR_W-1:0]            cfg_wr_data,
  input  wire logic [1:0]                          in_timbre,
  input  wire logic [pob_pkg::FREQ_W-1:0]          in_freq,
  input  wire logic signed [pob_pkg::GAIN_W-1:0]   in_gain,
  input  wire pob_pkg::pob_cmd_t                   cmd,
  output pob_pkg::pob_stat_t                       stat,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [pob_pkg::SAMPLE_W-1:0]      out_sample
);
  import pob_pkg::*;

  // voice store
  logic                     act_r    [VOICES];
  logic [1:0]               timbre_r [VOICES];
  logic [FREQ_W-1:0]        freq_r   [VOICES];
  logic signed [GAIN_W-1:0] gain_r   [VOICES];
  logic [PHASE_BITS-1:0]    phase_r  [VOICES];
  logic [PHASE_BITS-1:0]    step_r   [VOICES];

  logic [SR_W-1:0]   sr_r;
  logic [VIDX_W-1:0] vidx_r, slot_r, free_slot;
  logic [FREQ_W-1:0] key_r;
  logic              match, vidx_last;

  // divider
  logic [SR_W:0]           rem_r, rem_sh, rem_sub;
  logic [DVD_W-1:0]        dvd_r;
  logic [PHASE_BITS-1:0]   quo_r, quo_nxt;
  logic [DCNT_W-1:0]       dcnt_r;
  logic                    div_last, qbit;

  // mixing pipeline
  logic                     s1_v_r, s2_v_r;
  logic [1:0]               kind0, s1_kind_r, s2_kind_r;
  logic signed [GAIN_W-1:0] s1_gain_r;
  logic                     s1_low_r;
  logic signed [LUT_W-1:0]  rom_q_r;
  logic signed [GAIN_W:0]   s2_sq_r;
  logic signed [PROD_W-1:0] s2_prod_r;
  logic signed [PROD_W:0]   rnd;
  logic signed [SAMPLE_W-1:0] contrib, acc_r;
  logic                     out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic [PHASE_BITS-1:0]    cur_phase;
  logic [1:0]               cur_timbre;

  // first free voice, voice 0 when all busy
  always_comb begin
    free_slot = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!act_r[i]) free_slot = VIDX_W'(i);
    end
  end

  assign vidx_last = (vidx_r == VIDX_W'(VOICES - 1));
  assign match     = act_r[vidx_r] && (freq_r[vidx_r] == key_r);
  assign div_last  = (dcnt_r == DCNT_W'(DIV_STEPS - 1));

  // one restoring division bit per cycle
  assign rem_sh  = {rem_r[SR_W-1:0], dvd_r[DVD_W-1]};
  assign qbit    = (rem_sh >= {1'b0, sr_r});
  assign rem_sub = qbit ? (rem_sh - {1'b0, sr_r}) : rem_sh;
  assign quo_nxt = {quo_r[PHASE_BITS-2:0], qbit};

  assign cur_phase  = phase_r[vidx_r];
  assign cur_timbre = timbre_r[vidx_r];
  assign kind0 = (act_r[vidx_r] && (cur_timbre == TB_SQUARE || cur_timbre == TB_SINE))
                 ? cur_timbre : 2'(TB_SILENT0);

  // sample rate register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_r <= SR_RESET;
    end else if (cfg_wr_en) begin
      sr_r <= cfg_wr_data;
    end
  end

  // active flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) act_r[i] <= 1'b0;
    end else if (cmd.all_off) begin
      for (int i = 0; i < VOICES; i++) act_r[i] <= 1'b0;
    end else if (cmd.on_start) begin
      act_r[free_slot] <= 1'b1;
    end else if (cmd.off_step && match) begin
      act_r[vidx_r] <= 1'b0;
    end
  end

  // voice payload, phase advance and step write
  always_ff @(posedge clk) begin
    if (cmd.on_start) begin
      timbre_r[free_slot] <= in_timbre;
      freq_r[free_slot]   <= in_freq;
      gain_r[free_slot]   <= in_gain;
      phase_r[free_slot]  <= '0;
    end
    if (cmd.tick_rd && kind0 != 2'(TB_SILENT0)) begin
      phase_r[vidx_r] <= cur_phase + step_r[vidx_r];
    end
    if (cmd.div_step && div_last) begin
      step_r[slot_r] <= (sr_r == '0) ? '0 : quo_nxt;
    end
  end

  // voice index and search key
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vidx_r <= '0;
    end else if (cmd.tick_start || cmd.off_start) begin
      vidx_r <= '0;
    end else if (cmd.tick_rd || cmd.off_step) begin
      vidx_r <= vidx_r + VIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.off_start) key_r <= in_freq;
  end

  // divider registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.on_start) begin
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.on_start) begin
      slot_r <= free_slot;
      rem_r  <= '0;
      quo_r  <= '0;
      dvd_r  <= {in_freq, (PHASE_BITS - 8)'(0)};
    end else if (cmd.div_step) begin
      rem_r <= rem_sub;
      quo_r <= quo_nxt;
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.tick_rd;
      s2_v_r <= s1_v_r;
    end
  end

  // stage one: table read and voice fields
  always_ff @(posedge clk) begin
    rom_q_r   <= SINE_LUT[cur_phase[PHASE_BITS-1 -: SIDX_W]];
    s1_kind_r <= kind0;
    s1_gain_r <= gain_r[vidx_r];
    s1_low_r  <= !cur_phase[PHASE_BITS-1];
  end

  // stage two: multiply and square level
  always_ff @(posedge clk) begin
    s2_kind_r <= s1_kind_r;
    s2_prod_r <= s1_gain_r * rom_q_r;
    s2_sq_r   <= s1_low_r ? (GAIN_W+1)'(s1_gain_r) : -(GAIN_W+1)'(s1_gain_r);
  end

  // stage three: round half up and accumulate
  assign rnd = (PROD_W+1)'(s2_prod_r) + (PROD_W+1)'(16384);
  always_comb begin
    case (timbre_t'(s2_kind_r))
      TB_SQUARE: contrib = SAMPLE_W'(s2_sq_r);
      TB_SINE:   contrib = SAMPLE_W'(rnd >>> 15);
      default:   contrib = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      acc_r <= '0;
    end else if (s2_v_r) begin
      acc_r <= acc_r + contrib;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_sample_r <= acc_r;
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  assign stat.vidx_last = vidx_last;
  assign stat.div_last  = div_last;
  assign stat.match     = match;
  assign stat.pipe_busy = s1_v_r || s2_v_r;
  assign stat.out_free  = !out_valid_r || out_ready;

endmodule
`default_nettype wire

// ----- hdl/polyphonic_oscillator_bank.sv -----
// top level of the polyphonic oscillator bank
//
//  channel | ports                                   | direction
//  input   | in_valid in_ready in_op in_timbre ...   | in
//  result  | out_valid out_ready out_sample          | out
//  config  | cfg_wr_en cfg_wr_data                   | in
//
// tick: 16 voice reads through a 3-stage mix pipeline.
// note on: the accept cycle, then one quotient bit per cycle of the step divider.
// note off: one voice compared per cycle; all off: all active flags cleared on accept.
// synchronous reset clears all voices' active flags and sets sample rate 48000.
// a finished sample waits in the output register while the next transaction runs.
`default_nettype none
module polyphonic_oscillator_bank (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [pob_pkg::SR_W-1:0]          cfg_wr_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        in_op,
  input  wire logic [1:0]                        in_timbre,
  input  wire logic [pob_pkg::FREQ_W-1:0]        in_freq,
  input  wire logic signed [pob_pkg::GAIN_W-1:0] in_gain,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [pob_pkg::SAMPLE_W-1:0]    out_sample
);
  import pob_pkg::*;

  pob_cmd_t  cmd;
  pob_stat_t stat;

  // sequencing
  pob_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage and arithmetic
  pob_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_timbre   (in_timbre),
    .in_freq     (in_freq),
    .in_gain     (in_gain),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_sample  (out_sample)
  );

endmodule
`default_nettype wire

// ----- hdl/pob_checker.sv -----
// port-level checks for the oscillator bank and their bind
`default_nettype none
module pob_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_op,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [19:0] out_sample
);
  import pob_pkg::*;

  // a waiting sample holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("result changed while stalled");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // no transaction yields a result on the next cycle
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too soon");

  // multi-cycle operations block the input
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op != OP_ALL_OFF) |=> !in_ready)
    else $error("input ready during a running operation");

endmodule

bind polyphonic_oscillator_bank pob_checker u_pob_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .in_op      (in_op),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_sample (out_sample)
);
`default_nettype wire
